FILE: rtl/core/mism_pkg.sv
// Package for the multipath item spread block: field widths and stream packing.
// Used by multipath_item_spread_makespan; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mism_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 1;
  localparam int unsigned PIDX_W  = 4;
  localparam int unsigned PLEN_W  = 16;
  localparam int unsigned CNT_F_W = 20;
  localparam int unsigned TURNS_W = 21;
  localparam int unsigned CFG_W   = 5;

  // Stream packing, padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  // Command codes on in_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 1'b0,
    CMD_RUN  = 1'b1
  } cmd_t;

  typedef logic [TURNS_W-1:0] load_t;

endpackage
`default_nettype wire

FILE: rtl/core/multipath_item_spread_makespan.sv
// Top level of the multipath item spread block: path length store, greedy
// spread sequencer around one shared compare/increment unit. Uses mism_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   Input stream (in_*): in_tuser is the command. A load transaction
//   (in_tuser = 0) writes path_length into the length store at path_index;
//   it gives no result. A run transaction (in_tuser = 1)
//   spreads item_count items over the first paths_in_use paths and gives one
//   result transaction on out_* holding the final load of path 0 (turns).
//   Config port (cfg_*): 5-bit paths_in_use, ready out of reset; write only
//   while the block is idle. Zero counts as one path, values above MAX_PATHS
//   saturate.
//   Run sequence: the n path lengths are first copied into the running-load
//   memory. An item that returns to path 0 from the last path is handled in
//   ST_STEP alone; every other item passes ST_STEP (memory read of the next
//   path's load) and ST_EXEC (compare and increment). ST_STEP then sees the
//   count used up and ST_FIN posts the result. The shared comparator and the
//   single read port of the load memory set this sequence.
//   in_tready is low for the whole run. The result waits in an output
//   register; new transactions are taken while it waits, a finished run
//   holds until out_tready frees the register.
//   Reset (rst_n, synchronous, active low) clears the sequencer, the output
//   valid and sets paths_in_use to 1; stored lengths stay undefined until
//   loaded. Both ready outputs are low while reset is held.
module multipath_item_spread_makespan #(
  parameter int unsigned MAX_PATHS = 16
) (
  input  wire  logic                             clk,
  input  wire  logic                             rst_n,
  // in_tdata: path_index[3:0], path_length[19:4], item_count[39:20]
  input  wire  logic [mism_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: cmd[0]
  input  wire  logic [mism_pkg::CMD_W-1:0]       in_tuser,
  input  wire  logic                             in_tvalid,
  output logic                                   in_tready,
  // out_tdata: turns[20:0], zero pad [23:21]
  output logic [mism_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tvalid,
  input  wire  logic                             out_tready,
  input  wire  logic [mism_pkg::CFG_W-1:0]       cfg_data,
  input  wire  logic                             cfg_valid,
  output logic                                   cfg_ready
);
  import mism_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int unsigned NP_W  = $clog2(MAX_PATHS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COPY,
    ST_STEP,
    ST_EXEC,
    ST_FIN
  } state_t;

  // Input field unpacking
  logic [PIDX_W-1:0]  in_path_index;
  logic [PLEN_W-1:0]  in_path_length;
  logic [CNT_F_W-1:0] in_item_count;
  assign in_path_index  = in_tdata[PIDX_W-1:0];
  assign in_path_length = in_tdata[PIDX_W+PLEN_W-1:PIDX_W];
  assign in_item_count  = in_tdata[IN_TDATA_W-1:PIDX_W+PLEN_W];

  // Registers
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   cfg_paths_r;
  logic [NP_W-1:0]    npaths_r, npaths_nxt;
  logic [NP_W-1:0]    k_r, k_nxt;          // copy read counter
  logic               cp_v_r, cp_v_nxt;    // copy write pending
  logic [IDX_W-1:0]   cp_a_r, cp_a_nxt;
  logic [IDX_W-1:0]   cursor_r, cursor_nxt;
  logic [CNT_F_W-1:0] items_r, items_nxt;
  load_t              load0_r, load0_nxt;  // running load of path 0
  load_t              cur_r, cur_nxt;      // running load at the cursor
  logic               out_v_r, out_v_nxt;
  load_t              turns_r, turns_nxt;

  // Memories
  logic [PLEN_W-1:0]  len_mem [MAX_PATHS];
  load_t              run_mem [MAX_PATHS];
  logic [PLEN_W-1:0]  len_q;
  load_t              run_q;

  logic               in_acc;
  logic               len_we;
  logic [IDX_W-1:0]   len_waddr;
  logic [IDX_W-1:0]   len_raddr;
  logic               run_we;
  logic [IDX_W-1:0]   run_waddr;
  load_t              run_wdata;
  logic [IDX_W-1:0]   run_raddr;
  logic [NP_W-1:0]    next_idx;
  logic [NP_W-1:0]    cfg_np;

  assign in_tready  = rst_n && (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_TDATA_W - TURNS_W){1'b0}}, turns_r};

  // Active path count from the config register
  always_comb begin
    if (cfg_paths_r == '0) begin
      cfg_np = NP_W'(1);
    end else if (32'(cfg_paths_r) > MAX_PATHS) begin
      cfg_np = NP_W'(MAX_PATHS);
    end else begin
      cfg_np = NP_W'(cfg_paths_r);
    end
  end

  assign next_idx  = NP_W'(cursor_r) + NP_W'(1);
  assign len_we    = in_acc && (cmd_t'(in_tuser) == CMD_LOAD)
                     && (32'(in_path_index) < MAX_PATHS);
  assign len_waddr = IDX_W'(in_path_index);
  assign len_raddr = IDX_W'(k_r);
  assign run_raddr = IDX_W'(next_idx);

  // Length store
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= in_path_length;
    end
    len_q <= len_mem[len_raddr];
  end

  // Running-load memory
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    run_q <= run_mem[run_raddr];
  end

  // Sequencer next-state logic
  always_comb begin
    state_nxt  = state_r;
    npaths_nxt = npaths_r;
    k_nxt      = k_r;
    cp_v_nxt   = 1'b0;
    cp_a_nxt   = cp_a_r;
    cursor_nxt = cursor_r;
    items_nxt  = items_r;
    load0_nxt  = load0_r;
    cur_nxt    = cur_r;
    out_v_nxt  = out_v_r && !out_tready;
    turns_nxt  = turns_r;
    run_we     = 1'b0;
    run_waddr  = cp_a_r;
    run_wdata  = load_t'(len_q);

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (cmd_t'(in_tuser) == CMD_RUN)) begin
          npaths_nxt = cfg_np;
          items_nxt  = in_item_count;
          cursor_nxt = '0;
          k_nxt      = '0;
          state_nxt  = ST_COPY;
        end
      end
      ST_COPY: begin
        // read one length per cycle, write it in the cycle after
        if (k_r < npaths_r) begin
          k_nxt    = k_r + NP_W'(1);
          cp_v_nxt = 1'b1;
          cp_a_nxt = IDX_W'(k_r);
        end
        if (cp_v_r) begin
          run_we = 1'b1;
          if (cp_a_r == '0) begin
            load0_nxt = load_t'(len_q);
            cur_nxt   = load_t'(len_q);
          end
        end
        if (!(k_r < npaths_r) && !cp_v_r) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (items_r == '0) begin
          state_nxt = ST_FIN;
        end else if (next_idx < npaths_r) begin
          state_nxt = ST_EXEC;   // fetch load of the next path
        end else begin
          cursor_nxt = '0;
          load0_nxt  = load0_r + load_t'(1);
          cur_nxt    = load0_r + load_t'(1);
          items_nxt  = items_r - CNT_F_W'(1);
        end
      end
      ST_EXEC: begin
        // shared compare and increment
        if (cur_r > run_q) begin
          cursor_nxt = IDX_W'(next_idx);
          cur_nxt    = run_q + load_t'(1);
          run_we     = 1'b1;
          run_waddr  = IDX_W'(next_idx);
          run_wdata  = run_q + load_t'(1);
        end else begin
          cursor_nxt = '0;
          load0_nxt  = load0_r + load_t'(1);
          cur_nxt    = load0_r + load_t'(1);
        end
        items_nxt = items_r - CNT_F_W'(1);
        state_nxt = ST_STEP;
      end
      ST_FIN: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          turns_nxt = load0_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_paths_r <= CFG_W'(1);
      out_v_r     <= 1'b0;
      cp_v_r      <= 1'b0;
      k_r         <= '0;
      cursor_r    <= '0;
      items_r     <= '0;
      npaths_r    <= NP_W'(1);
    end else begin
      state_r  <= state_nxt;
      out_v_r  <= out_v_nxt;
      cp_v_r   <= cp_v_nxt;
      k_r      <= k_nxt;
      cursor_r <= cursor_nxt;
      items_r  <= items_nxt;
      npaths_r <= npaths_nxt;
      if (cfg_valid && cfg_ready) begin
        cfg_paths_r <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cp_a_r  <= cp_a_nxt;
    load0_r <= load0_nxt;
    cur_r   <= cur_nxt;
    turns_r <= turns_nxt;
  end

endmodule
`default_nettype wire
